>>> hw/rtl/hmbr_pkg.sv
`default_nettype none

package hmbr_pkg;

    // store depths
    localparam int VIDEO_BYTES  = 8192;
    localparam int WORK_BYTES   = 8192;
    localparam int OBJECT_BYTES = 160;

    // bus map section bases
    localparam logic [15:0] VIDEO_BASE    = 16'h8000;
    localparam logic [15:0] CART_RAM_BASE = 16'hA000;
    localparam logic [15:0] WORK_BASE     = 16'hC000;
    localparam logic [15:0] ECHO_BASE     = 16'hE000;
    localparam logic [15:0] OBJECT_BASE   = 16'hFE00;
    localparam logic [15:0] IO_BASE       = 16'hFF00;
    localparam logic [15:0] BANK_SPAN     = 16'h2000;
    localparam logic [7:0]  BLOCKED_BYTE  = 8'hFF;

    // route codes
    typedef enum logic [2:0] {
        ROUTE_ROM      = 3'd0,
        ROUTE_CART_RAM = 3'd1,
        ROUTE_IO       = 3'd2,
        ROUTE_STORE    = 3'd3,
        ROUTE_DMA      = 3'd4,
        ROUTE_BLOCKED  = 3'd5
    } t_route;

    // where the result byte comes from
    typedef enum logic [1:0] {
        SRC_FIXED  = 2'd0,
        SRC_VIDEO  = 2'd1,
        SRC_WORK   = 2'd2,
        SRC_OBJECT = 2'd3
    } t_src;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_LOOKUP = 2'd2
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

>>> hw/rtl/hmbr_ctrl.sv
`default_nettype none

module hmbr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire hmbr_pkg::t_status i_status,
    output hmbr_pkg::t_cmd        o_cmd
);

    hmbr_pkg::t_state r_state;
    hmbr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hmbr_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hmbr_pkg::ST_CLEAR: begin
                if (i_status.clear_done) n_state = hmbr_pkg::ST_IDLE;
            end
            hmbr_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = hmbr_pkg::ST_LOOKUP;
            end
            hmbr_pkg::ST_LOOKUP: begin
                if (i_status.out_free) n_state = hmbr_pkg::ST_IDLE;
            end
            default: n_state = hmbr_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            hmbr_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            hmbr_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            hmbr_pkg::ST_LOOKUP: begin
                o_cmd.load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_no_ready_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hmbr_pkg::ST_CLEAR) |-> !o_in_ready)
        else $error("input ready during store clear");

    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == hmbr_pkg::ST_LOOKUP))
        else $error("accepted access did not enter lookup");

    a_load_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == hmbr_pkg::ST_IDLE))
        else $error("result load did not return to idle");

endmodule

`default_nettype wire

>>> hw/rtl/hmbr_datapath.sv
`default_nettype none

module hmbr_datapath #(
    parameter int VIDEO_BYTES  = hmbr_pkg::VIDEO_BYTES,
    parameter int OBJECT_BYTES = hmbr_pkg::OBJECT_BYTES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire hmbr_pkg::t_cmd   i_cmd,
    output hmbr_pkg::t_status     o_status,
    input  wire logic             i_action,
    input  wire logic [15:0]      i_address,
    input  wire logic [7:0]       i_write_byte,
    input  wire logic [1:0]       i_lcd_mode,
    input  wire logic             i_dma_busy,
    input  wire logic [15:0]      i_dma_source,
    input  wire logic [7:0]       i_dma_position,
    input  wire logic [7:0]       i_dma_latched_byte,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output hmbr_pkg::t_route      o_route,
    output logic [7:0]            o_read_byte,
    output logic [15:0]           o_forward_address
);

    localparam int VAW   = $clog2(VIDEO_BYTES);
    localparam int WAW   = $clog2(hmbr_pkg::WORK_BYTES);
    localparam int OAW   = $clog2(OBJECT_BYTES);
    localparam int CLR_W = (VAW > WAW) ? VAW : WAW;
    localparam int CLR_N = (VIDEO_BYTES > hmbr_pkg::WORK_BYTES) ?
                           VIDEO_BYTES : hmbr_pkg::WORK_BYTES;
    localparam logic [CLR_W-1:0]  CLR_LAST = CLR_W'(CLR_N - 1);
    localparam logic [15:0] VIDEO_END  = 16'(hmbr_pkg::VIDEO_BASE + VIDEO_BYTES);
    localparam logic [15:0] CART_END   = 16'(hmbr_pkg::CART_RAM_BASE + hmbr_pkg::BANK_SPAN);
    localparam logic [15:0] OBJECT_END = 16'(hmbr_pkg::OBJECT_BASE + OBJECT_BYTES);

    // decode of the incoming access
    logic [15:0]       dma_target;
    logic              a_video;
    logic              a_cart;
    logic              a_object;
    logic              a_work;
    logic              a_unusable;
    logic              dma_video;
    hmbr_pkg::t_route  dec_route;
    hmbr_pkg::t_src    dec_src;
    logic [7:0]        dec_byte;
    logic [15:0]       dec_fwd;
    logic              dec_store_wr;

    always_comb begin
        dma_target = i_dma_source + 16'(i_dma_position);
        a_video    = (i_address >= hmbr_pkg::VIDEO_BASE) && (i_address < VIDEO_END);
        dma_video  = (dma_target >= hmbr_pkg::VIDEO_BASE) && (dma_target < VIDEO_END);
        a_cart     = (i_address >= hmbr_pkg::CART_RAM_BASE) && (i_address < CART_END);
        a_object   = (i_address >= hmbr_pkg::OBJECT_BASE) && (i_address < OBJECT_END);
        a_work     = (i_address >= hmbr_pkg::WORK_BASE) && (i_address < hmbr_pkg::OBJECT_BASE);
        a_unusable = (i_address >= OBJECT_END) && (i_address < hmbr_pkg::IO_BASE);

        dec_route    = hmbr_pkg::ROUTE_STORE;
        dec_src      = hmbr_pkg::SRC_FIXED;
        dec_byte     = 8'h00;
        dec_fwd      = 16'h0000;
        dec_store_wr = 1'b0;

        if (!i_action) begin
            if (i_dma_busy && (i_address < hmbr_pkg::OBJECT_BASE) && (dma_video == a_video)) begin
                dec_route = hmbr_pkg::ROUTE_DMA;
                dec_byte  = i_dma_latched_byte;
            end else if (i_address < hmbr_pkg::VIDEO_BASE) begin
                dec_route = hmbr_pkg::ROUTE_ROM;
                dec_fwd   = i_address;
            end else if (a_cart) begin
                dec_route = hmbr_pkg::ROUTE_CART_RAM;
                dec_fwd   = i_address;
            end else if (a_video && (i_lcd_mode == 2'd3)) begin
                dec_route = hmbr_pkg::ROUTE_BLOCKED;
                dec_byte  = hmbr_pkg::BLOCKED_BYTE;
            end else if (a_object && (i_dma_busy || i_lcd_mode[1])) begin
                dec_route = hmbr_pkg::ROUTE_BLOCKED;
                dec_byte  = hmbr_pkg::BLOCKED_BYTE;
            end else if (i_address >= hmbr_pkg::IO_BASE) begin
                dec_route = hmbr_pkg::ROUTE_IO;
                dec_fwd   = i_address;
            end else if (a_video) begin
                dec_src = hmbr_pkg::SRC_VIDEO;
            end else if (a_work) begin
                dec_src = hmbr_pkg::SRC_WORK;
            end else if (a_object) begin
                dec_src = hmbr_pkg::SRC_OBJECT;
            end
            // unusable area falls through as a store read of zero
        end else begin
            if (i_dma_busy && (i_address < hmbr_pkg::IO_BASE)) begin
                dec_route = hmbr_pkg::ROUTE_BLOCKED;
            end else if (i_address < hmbr_pkg::VIDEO_BASE) begin
                dec_route = hmbr_pkg::ROUTE_ROM;
                dec_fwd   = i_address;
            end else if (a_cart) begin
                dec_route = hmbr_pkg::ROUTE_CART_RAM;
                dec_fwd   = i_address;
            end else if (a_video && (i_lcd_mode == 2'd3)) begin
                dec_route = hmbr_pkg::ROUTE_BLOCKED;
            end else if (a_object && i_lcd_mode[1]) begin
                dec_route = hmbr_pkg::ROUTE_BLOCKED;
            end else if (a_unusable) begin
                dec_route = hmbr_pkg::ROUTE_BLOCKED;
            end else if (i_address >= hmbr_pkg::IO_BASE) begin
                dec_route = hmbr_pkg::ROUTE_IO;
                dec_fwd   = i_address;
            end else begin
                dec_store_wr = 1'b1;
            end
        end
    end

    // store indexes; echo fold keeps the low bits of the work index
    logic [VAW-1:0] vid_idx;
    logic [WAW-1:0] work_idx;
    logic [OAW-1:0] obj_idx;

    always_comb begin
        vid_idx  = VAW'(i_address - hmbr_pkg::VIDEO_BASE);
        work_idx = i_address[WAW-1:0];
        obj_idx  = OAW'(i_address - hmbr_pkg::OBJECT_BASE);
    end

    // clear sweep over video and work stores
    logic [CLR_W-1:0] r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + CLR_W'(1);
        end
    end

    // video store
    logic [7:0] r_vid_mem [VIDEO_BYTES];
    logic [7:0] r_vid_q;
    logic       vid_we;
    logic       vid_re;
    logic [VAW-1:0] vid_waddr;
    logic [7:0] vid_wdata;

    always_comb begin
        vid_we    = i_cmd.clear || (i_cmd.accept && dec_store_wr && a_video);
        vid_re    = i_cmd.accept && (dec_src == hmbr_pkg::SRC_VIDEO);
        vid_waddr = i_cmd.clear ? r_clr[VAW-1:0] : vid_idx;
        vid_wdata = i_cmd.clear ? 8'h00 : i_write_byte;
    end

    always_ff @(posedge i_clk) begin
        if (vid_we) begin
            r_vid_mem[vid_waddr] <= vid_wdata;
        end
        if (vid_re) begin
            r_vid_q <= r_vid_mem[vid_idx];
        end
    end

    // work store
    logic [7:0] r_work_mem [hmbr_pkg::WORK_BYTES];
    logic [7:0] r_work_q;
    logic       work_we;
    logic       work_re;
    logic [WAW-1:0] work_waddr;
    logic [7:0] work_wdata;

    always_comb begin
        work_we    = i_cmd.clear || (i_cmd.accept && dec_store_wr && a_work);
        work_re    = i_cmd.accept && (dec_src == hmbr_pkg::SRC_WORK);
        work_waddr = i_cmd.clear ? r_clr[WAW-1:0] : work_idx;
        work_wdata = i_cmd.clear ? 8'h00 : i_write_byte;
    end

    always_ff @(posedge i_clk) begin
        if (work_we) begin
            r_work_mem[work_waddr] <= work_wdata;
        end
        if (work_re) begin
            r_work_q <= r_work_mem[work_idx];
        end
    end

    // object store, valid bits stand in for the reset value
    logic [7:0]              r_obj_mem [OBJECT_BYTES];
    logic [OBJECT_BYTES-1:0] r_obj_vld;
    logic [7:0]              r_obj_q;
    logic                    r_obj_qv;
    logic                    obj_we;
    logic                    obj_re;

    always_comb begin
        obj_we = i_cmd.accept && dec_store_wr && a_object;
        obj_re = i_cmd.accept && (dec_src == hmbr_pkg::SRC_OBJECT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_vld <= '0;
        end else if (obj_we) begin
            r_obj_vld[obj_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (obj_we) begin
            r_obj_mem[obj_idx] <= i_write_byte;
        end
        if (obj_re) begin
            r_obj_q  <= r_obj_mem[obj_idx];
            r_obj_qv <= r_obj_vld[obj_idx];
        end
    end

    // decoded fields held for the lookup cycle
    hmbr_pkg::t_route r_route;
    hmbr_pkg::t_src   r_src;
    logic [7:0]       r_byte;
    logic [15:0]      r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_route <= dec_route;
            r_src   <= dec_src;
            r_byte  <= dec_byte;
            r_fwd   <= dec_fwd;
        end
    end

    logic [7:0] sel_byte;

    always_comb begin
        case (r_src)
            hmbr_pkg::SRC_VIDEO:  sel_byte = r_vid_q;
            hmbr_pkg::SRC_WORK:   sel_byte = r_work_q;
            hmbr_pkg::SRC_OBJECT: sel_byte = r_obj_qv ? r_obj_q : 8'h00;
            default:              sel_byte = r_byte;
        endcase
    end

    // output register
    logic             r_out_valid;
    hmbr_pkg::t_route r_out_route;
    logic [7:0]       r_out_byte;
    logic [15:0]      r_out_fwd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_route <= r_route;
            r_out_byte  <= sel_byte;
            r_out_fwd   <= r_fwd;
        end
    end

    always_comb begin
        o_status.clear_done = i_cmd.clear && (r_clr == CLR_LAST);
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_out_valid         = r_out_valid;
        o_route             = r_out_route;
        o_read_byte         = r_out_byte;
        o_forward_address   = r_out_fwd;
    end

    a_route_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_route <= hmbr_pkg::ROUTE_BLOCKED))
        else $error("illegal route code");

    a_forward_only_external: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_route == hmbr_pkg::ROUTE_STORE
                      || r_out_route == hmbr_pkg::ROUTE_DMA
                      || r_out_route == hmbr_pkg::ROUTE_BLOCKED)) |-> (r_out_fwd == 16'h0000))
        else $error("forward address on internal route");

    a_byte_only_internal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_route == hmbr_pkg::ROUTE_ROM
                      || r_out_route == hmbr_pkg::ROUTE_CART_RAM
                      || r_out_route == hmbr_pkg::ROUTE_IO)) |-> (r_out_byte == 8'h00))
        else $error("read byte on external route");

    a_no_store_access_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |-> !(obj_we || obj_re || vid_re || work_re))
        else $error("store access during clear sweep");

endmodule

`default_nettype wire

>>> hw/rtl/handheld_memory_bus_router.sv
`default_nettype none

// memory bus router for a handheld console cpu. each transfer on the slave
// stream is one cpu bus access (read or write) plus the current lcd mode and
// the object-memory dma state; the master stream returns one transfer per
// access with its route (rom, cart ram, io, internal store, dma conflict,
// blocked), the read byte and the forwarded address. the block owns video
// ram (0x8000-0x9fff), work ram (0xc000-0xdfff with its echo at
// 0xe000-0xfdff) and object memory (0xfe00-0xfe9f). after reset a clearing
// pass zeroes video and work ram, during which no access is taken. the
// accept cycle does the decode and any store write; the lookup state then
// waits for the registered store read port and loads the output register. a
// finished result can wait in the output register while the next access is
// accepted; the router stalls in its lookup state only if the previous
// result is still untaken.

module handheld_memory_bus_router #(
    parameter int VIDEO_BYTES  = hmbr_pkg::VIDEO_BYTES,
    parameter int OBJECT_BYTES = hmbr_pkg::OBJECT_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // access stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] address, [23:16] write_byte, [25:24] lcd_mode, [26] dma_busy,
    // [42:27] dma_source, [50:43] dma_position, [58:51] dma_latched_byte,
    // [63:59] zero
    input  wire logic [63:0] s_axis_tdata,
    // [0] action
    input  wire logic        s_axis_tuser,
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] read_byte, [23:8] forward_address
    output logic [23:0]      m_axis_tdata,
    // [2:0] route
    output logic [2:0]       m_axis_tuser
);

    hmbr_pkg::t_cmd    cmd;
    hmbr_pkg::t_status status;
    hmbr_pkg::t_route  route;
    logic [7:0]        read_byte;
    logic [15:0]       forward_address;

    // sequencing of clear, accept and lookup
    hmbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // decode, stores and output register
    hmbr_datapath #(
        .VIDEO_BYTES  (VIDEO_BYTES),
        .OBJECT_BYTES (OBJECT_BYTES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_action           (s_axis_tuser),
        .i_address          (s_axis_tdata[15:0]),
        .i_write_byte       (s_axis_tdata[23:16]),
        .i_lcd_mode         (s_axis_tdata[25:24]),
        .i_dma_busy         (s_axis_tdata[26]),
        .i_dma_source       (s_axis_tdata[42:27]),
        .i_dma_position     (s_axis_tdata[50:43]),
        .i_dma_latched_byte (s_axis_tdata[58:51]),
        .o_out_valid        (m_axis_tvalid),
        .i_out_ready        (m_axis_tready),
        .o_route            (route),
        .o_read_byte        (read_byte),
        .o_forward_address  (forward_address)
    );

    // pack result fields
    assign m_axis_tdata = {forward_address, read_byte};
    assign m_axis_tuser = route;

endmodule

`default_nettype wire
